>>> hdl/assert_macros.svh
// Assertion helpers for the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/elc_pkg.sv
// ---------------------------------------------------------------------------
// elc_pkg
// Shared widths, constants and command/status types of the edge classifier.
// ---------------------------------------------------------------------------
`default_nettype none
package elc_pkg;
  localparam int CoordW      = 28;
  localparam int DiffW       = 29;
  localparam int SqW         = 58;
  localparam int SumW        = 60;
  localparam int LenW        = 29;
  localparam int QuantW      = 25;
  localparam int KeyW        = 30;
  localparam int CatW        = 6;
  localparam int MaxClasses  = 64;
  localparam logic [QuantW-1:0] QuantumReset = QuantW'(168);

  typedef struct packed {
    logic load;      // latch input beat, start squaring
    logic sq_step;   // square next axis difference
    logic root_step; // one root iteration
    logic div_step;  // one divider iteration
    logic div_init;  // start divider
    logic rd_key;    // issue key read
    logic wr_key;    // write key at class count
  } elc_cmd_t;

  typedef struct packed {
    logic sq_done;
    logic root_done;
    logic div_done;
  } elc_sts_t;
endpackage
`default_nettype wire

>>> hdl/elc_if.sv
// ---------------------------------------------------------------------------
// elc_if
// Valid/ready channel carrying one payload beat.
// ---------------------------------------------------------------------------
`default_nettype none
interface elc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/elc_ram.sv
// ---------------------------------------------------------------------------
// elc_ram
// RAM with one write port and one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module elc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/elc_datapath.sv
// ---------------------------------------------------------------------------
// elc_datapath
// Squares, serial root and serial divider producing length and key.
// ---------------------------------------------------------------------------
`default_nettype none
module elc_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire elc_pkg::elc_cmd_t                 cmd,
  output elc_pkg::elc_sts_t                      sts,
  input  wire logic signed [elc_pkg::CoordW-1:0] ax,
  input  wire logic signed [elc_pkg::CoordW-1:0] ay,
  input  wire logic signed [elc_pkg::CoordW-1:0] az,
  input  wire logic signed [elc_pkg::CoordW-1:0] bx,
  input  wire logic signed [elc_pkg::CoordW-1:0] by_coord,
  input  wire logic signed [elc_pkg::CoordW-1:0] bz,
  input  wire logic        [elc_pkg::QuantW-1:0] quantum,
  output logic             [elc_pkg::LenW-1:0]   edge_length,
  output logic             [elc_pkg::KeyW-1:0]   key
);
  localparam int DW = elc_pkg::DiffW;
  localparam int SW = elc_pkg::SumW;
  localparam int LW = elc_pkg::LenW;
  localparam int QW = elc_pkg::QuantW;
  localparam int KW = elc_pkg::KeyW;

  logic signed [DW-1:0] dif [3];
  logic [1:0]           axis;
  logic [SW-1:0]        sum;
  logic [SW-1:0]        rem;
  logic [5:0]           rcnt;
  logic [4:0]           dcnt;
  logic [QW-1:0]        divisor;
  logic [QW:0]          drem;
  logic [LW-1:0]        quo;
  logic [DW-2:0]        mag;
  logic [SW+1:0]        trial;
  logic [SW-1:0]        rem_sh;
  logic [QW:0]          dsh;

  assign mag = dif[axis][DW-1] ? (DW-1)'(-dif[axis]) : dif[axis][DW-2:0];
  // Restoring root: two remainder bits per iteration.
  assign rem_sh = {rem[SW-3:0], sum[SW-1:SW-2]};
  assign trial  = {2'b00, rem_sh} - {2'b00, {(SW-LW-2){1'b0}}, edge_length, 2'b01};
  assign dsh    = {drem[QW-1:0], quo[LW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
    end else begin
      if (cmd.load) begin
        dif[0] <= DW'(ax) - DW'(bx);
        dif[1] <= DW'(ay) - DW'(by_coord);
        dif[2] <= DW'(az) - DW'(bz);
        axis   <= '0;
        sum    <= '0;
        sts    <= '0;
      end
      if (cmd.sq_step) begin
        sum  <= sum + SW'(mag * mag);
        axis <= axis + 2'd1;
        sts.sq_done <= (axis == 2'd2);
        rem  <= '0;
        edge_length <= '0;
        rcnt <= '0;
      end
      if (cmd.root_step) begin
        sum <= {sum[SW-3:0], 2'b00};
        if (!trial[SW+1]) begin
          rem         <= trial[SW-1:0];
          edge_length <= {edge_length[LW-2:0], 1'b1};
        end else begin
          rem         <= rem_sh;
          edge_length <= {edge_length[LW-2:0], 1'b0};
        end
        rcnt <= rcnt + 6'd1;
        sts.root_done <= (rcnt == 6'(SW/2 - 1));
      end
      if (cmd.div_init) begin
        divisor <= (quantum == '0) ? QW'(1) : quantum;
        drem    <= '0;
        quo     <= edge_length;
        dcnt    <= '0;
      end
      if (cmd.div_step) begin
        if (dsh >= {1'b0, divisor}) begin
          drem <= dsh - {1'b0, divisor};
          quo  <= {quo[LW-2:0], 1'b1};
        end else begin
          drem <= dsh;
          quo  <= {quo[LW-2:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
        sts.div_done <= (dcnt == 5'(LW - 1));
      end
    end
  end

  assign key = KW'(quo) + KW'(1);
endmodule
`default_nettype wire

>>> hdl/elc_ctrl.sv
// ---------------------------------------------------------------------------
// elc_ctrl
// Sequencer: handshake, datapath commands, class table search and result.
// ---------------------------------------------------------------------------
`default_nettype none
module elc_ctrl #(
  parameter int MaxClasses = elc_pkg::MaxClasses
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        first_edge,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output elc_pkg::elc_cmd_t                cmd,
  input  wire elc_pkg::elc_sts_t           sts,
  input  wire logic [elc_pkg::KeyW-1:0]    key,
  input  wire logic [elc_pkg::KeyW-1:0]    rd_key,
  output logic [$clog2(MaxClasses)-1:0]    addr,
  output logic [elc_pkg::CatW-1:0]         category,
  output logic                             is_new,
  output logic                             table_full
);
  localparam int AW = $clog2(MaxClasses);
  localparam int CW = $clog2(MaxClasses + 1);

  typedef enum logic [3:0] {
    IDLE, SQUARE, ROOT, DIVINIT, DIVIDE, SEARCH, COMPARE, RESULT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == RESULT);
  assign addr      = (state == COMPARE && idx == count) ? count[AW-1:0] : idx[AW-1:0];

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:    cmd.load      = in_valid;
      SQUARE:  cmd.sq_step   = !sts.sq_done;
      ROOT:    cmd.root_step = !sts.root_done;
      DIVINIT: cmd.div_init  = 1'b1;
      DIVIDE:  cmd.div_step  = !sts.div_done;
      SEARCH:  cmd.rd_key    = 1'b1;
      COMPARE: cmd.wr_key    = (idx == count) && (count < CW'(MaxClasses));
      RESULT:  cmd           = '0;
      default: cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            if (first_edge) begin
              count <= '0;
            end
            state <= SQUARE;
          end
        end
        SQUARE:  if (sts.sq_done) state <= ROOT;
        ROOT:    if (sts.root_done) state <= DIVINIT;
        DIVINIT: state <= DIVIDE;
        DIVIDE: begin
          if (sts.div_done) begin
            idx   <= '0;
            state <= SEARCH;
          end
        end
        SEARCH: state <= COMPARE;
        COMPARE: begin
          if (idx == count) begin
            state <= RESULT;
            if (count < CW'(MaxClasses)) begin
              category   <= elc_pkg::CatW'(count);
              is_new     <= 1'b1;
              table_full <= 1'b0;
              count      <= count + CW'(1);
            end else begin
              category   <= '0;
              is_new     <= 1'b0;
              table_full <= 1'b1;
            end
          end else if (rd_key == key) begin
            category   <= elc_pkg::CatW'(idx);
            is_new     <= 1'b0;
            table_full <= 1'b0;
            state      <= RESULT;
          end else begin
            idx   <= idx + CW'(1);
            state <= SEARCH;
          end
        end
        RESULT:  if (out_ready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/edge_length_classifier.sv
// ---------------------------------------------------------------------------
// edge_length_classifier
// Edge length, quantized length class and class table lookup.
// ---------------------------------------------------------------------------
// Usage: one input beat carries both endpoints and first_edge; one output
// beat returns category, is_new, edge_length and table_full. quantum must be
// written through cfg_we/cfg_data only while idle, which the block does not
// enforce; zero acts as one. One item at a time: in.ready is high only while
// idle. From the accepting edge, the squares of the three axis differences,
// the serial root, the divider setup, the serial divide and a key read and
// compare per stored class until one matches, or else the append or full
// decision, come before out.valid rises. The next beat can be taken in the
// cycle after the result is delivered; the serial root and divider and the
// single key RAM address set how long an item occupies the block.
// Reset empties the class table and sets quantum to 168. A stalled receiver
// holds the result on out; no new beat is taken until it is delivered.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module edge_length_classifier #(
  parameter int MaxClasses = elc_pkg::MaxClasses
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cfg_we,
  input wire logic [elc_pkg::QuantW-1:0]  cfg_data,
  elc_if.sink                             in,
  elc_if.source                           out
);
  elc_pkg::elc_cmd_t               cmd;
  elc_pkg::elc_sts_t               sts;
  logic [elc_pkg::QuantW-1:0]      quantum;
  logic [elc_pkg::KeyW-1:0]        key;
  logic [elc_pkg::KeyW-1:0]        rd_key;
  logic [$clog2(MaxClasses)-1:0]   addr;
  logic [elc_pkg::LenW-1:0]        edge_length;
  logic [elc_pkg::CatW-1:0]        category;
  logic                            is_new;
  logic                            table_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= elc_pkg::QuantumReset;
    end else if (cfg_we) begin
      quantum <= cfg_data;
    end
  end

  elc_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .ax(in.data.ax), .ay(in.data.ay), .az(in.data.az),
    .bx(in.data.bx), .by_coord(in.data.by_coord), .bz(in.data.bz),
    .quantum, .edge_length, .key
  );

  elc_ctrl #(.MaxClasses(MaxClasses)) u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready), .first_edge(in.data.first_edge),
    .out_valid(out.valid), .out_ready(out.ready),
    .cmd, .sts, .key, .rd_key, .addr, .category, .is_new, .table_full
  );

  elc_ram #(.Width(elc_pkg::KeyW), .Depth(MaxClasses)) u_keys (
    .clk, .we(cmd.wr_key), .waddr(addr), .wdata(key), .raddr(addr), .rdata(rd_key)
  );

  assign out.data.category    = category;
  assign out.data.is_new      = is_new;
  assign out.data.edge_length = edge_length;
  assign out.data.table_full  = table_full;

  `ASSERT_IMPL(a_no_in_while_out, clk, rst, out.valid, !in.ready)
  `ASSERT_IMPL(a_new_not_full, clk, rst, out.valid, !(is_new && table_full))
  `ASSERT_NEXT(a_take_starts, clk, rst, in.valid && in.ready, !in.ready && !out.valid)
endmodule
`default_nettype wire
